[rtl/rect_corner_order_by_distance_unit_macros.svh]
// Assertion macros shared by the rect corner order checker.
`ifndef RECT_CORNER_ORDER_BY_DISTANCE_UNIT_MACROS_SVH
`define RECT_CORNER_ORDER_BY_DISTANCE_UNIT_MACROS_SVH

// Plain property, sampled on clock, off during reset.
`define RCOD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("rect corner order check failed");

// Implication form built on the plain one.
`define RCOD_IMPLY(label, ante, cons) \
   `RCOD_ASSERT(label, (ante) |-> (cons))

`endif

[rtl/rcod_pkg.sv]
// Types and constants of the rect corner order block.
`default_nettype none

package rcod_pkg;

   localparam int COORD_BITS  = 16;
   localparam int NUM_CORNERS = 4;
   localparam int IDX_BITS    = $clog2(NUM_CORNERS);
   localparam int ABS_BITS    = COORD_BITS;       // |a - b| fits unsigned
   localparam int SQ_BITS     = 2 * ABS_BITS;
   localparam int DIST_BITS   = SQ_BITS + 1;
   localparam int RSP_LATENCY = 6;                // start edge to strobe sample

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } corner_type;

   typedef corner_type [NUM_CORNERS-1:0] corner_vec_type;
   typedef logic [NUM_CORNERS-1:0][DIST_BITS-1:0] dist_vec_type;

   typedef struct packed {
      coord_type v0_x;
      coord_type v0_y;
      coord_type v1_x;
      coord_type v1_y;
      coord_type v2_x;
      coord_type v2_y;
      coord_type v3_x;
      coord_type v3_y;
   } req_word_type;

   typedef struct packed {
      coord_type o0_x;
      coord_type o0_y;
      coord_type o1_x;
      coord_type o1_y;
      coord_type o2_x;
      coord_type o2_y;
      coord_type o3_x;
      coord_type o3_y;
   } rsp_word_type;

endpackage

`default_nettype wire

[rtl/rect_corner_order_by_distance_unit.sv]
// A word taken at a start edge passes every register listed under Path below and
// shows on rsp_word, with rsp_strobe, for one cycle.
// Throughput: one word per cycle; busy stays low.
// Path: input reg, reference pick, abs diffs, 16x16 squares, distance sum,
// rank and output reg. Synchronous reset clears the valid bits only; words in
// flight are dropped.
`default_nettype none

module rect_corner_order_by_distance_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire rcod_pkg::req_word_type req_word,
   output logic                        rsp_strobe,
   output rcod_pkg::rsp_word_type      rsp_word
);
   import rcod_pkg::*;

   // input register
   logic           in_valid_ff;
   corner_vec_type in_pts_ff, in_pts_in;

   // reference pick
   logic           ref_valid_ff;
   corner_type     ref_pt_ff, ref_pt_in;
   corner_vec_type ref_pts_ff;

   // absolute differences
   logic                                 diff_valid_ff;
   logic [NUM_CORNERS-1:0][ABS_BITS-1:0] adx_ff, adx_in, ady_ff, ady_in;
   corner_vec_type                       diff_pts_ff;

   // squares
   logic                                sq_valid_ff;
   logic [NUM_CORNERS-1:0][SQ_BITS-1:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   corner_vec_type                      sq_pts_ff;

   // distance sums
   logic           sum_valid_ff;
   dist_vec_type   dist_ff, dist_in;
   corner_vec_type sum_pts_ff;

   function automatic logic ranks_above(corner_type a, corner_type b);
      return ($signed(a.y) > $signed(b.y)) ||
             (($signed(a.y) == $signed(b.y)) && ($signed(a.x) > $signed(b.x)));
   endfunction

   assign busy = 1'b0;

   always_comb begin
      in_pts_in[0] = '{x: req_word.v0_x, y: req_word.v0_y};
      in_pts_in[1] = '{x: req_word.v1_x, y: req_word.v1_y};
      in_pts_in[2] = '{x: req_word.v2_x, y: req_word.v2_y};
      in_pts_in[3] = '{x: req_word.v3_x, y: req_word.v3_y};
   end

   // keep the two highest ranked corners, then take the one with larger x
   always_comb begin
      corner_type top1, top2;
      top1 = in_pts_ff[0];
      top2 = in_pts_ff[1];
      if (ranks_above(in_pts_ff[1], in_pts_ff[0])) begin
         top1 = in_pts_ff[1];
         top2 = in_pts_ff[0];
      end
      for (int i = 2; i < NUM_CORNERS; i++) begin
         priority if (ranks_above(in_pts_ff[i], top1)) begin
            top2 = top1;
            top1 = in_pts_ff[i];
         end else if (ranks_above(in_pts_ff[i], top2)) begin
            top2 = in_pts_ff[i];
         end
      end
      ref_pt_in = ($signed(top1.x) >= $signed(top2.x)) ? top1 : top2;
   end

   always_comb begin
      logic signed [COORD_BITS:0] dx, dy;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         dx = {ref_pt_ff.x[COORD_BITS-1], ref_pt_ff.x} -
              {ref_pts_ff[i].x[COORD_BITS-1], ref_pts_ff[i].x};
         dy = {ref_pt_ff.y[COORD_BITS-1], ref_pt_ff.y} -
              {ref_pts_ff[i].y[COORD_BITS-1], ref_pts_ff[i].y};
         adx_in[i] = dx[COORD_BITS] ? ABS_BITS'(-dx) : ABS_BITS'(dx);
         ady_in[i] = dy[COORD_BITS] ? ABS_BITS'(-dy) : ABS_BITS'(dy);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         sqx_in[i] = SQ_BITS'(adx_ff[i]) * SQ_BITS'(adx_ff[i]);
         sqy_in[i] = SQ_BITS'(ady_ff[i]) * SQ_BITS'(ady_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         dist_in[i] = DIST_BITS'(sqx_ff[i]) + DIST_BITS'(sqy_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         ref_valid_ff  <= 1'b0;
         diff_valid_ff <= 1'b0;
         sq_valid_ff   <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= start & ~busy;
         ref_valid_ff  <= in_valid_ff;
         diff_valid_ff <= ref_valid_ff;
         sq_valid_ff   <= diff_valid_ff;
         sum_valid_ff  <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_pts_ff   <= in_pts_in;
      ref_pt_ff   <= ref_pt_in;
      ref_pts_ff  <= in_pts_ff;
      adx_ff      <= adx_in;
      ady_ff      <= ady_in;
      diff_pts_ff <= ref_pts_ff;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      sq_pts_ff   <= diff_pts_ff;
      dist_ff     <= dist_in;
      sum_pts_ff  <= sq_pts_ff;
   end

   rcod_sort u_sort (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sum_valid_ff),
      .in_dist    (dist_ff),
      .in_pts     (sum_pts_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire

[rtl/rcod_sort.sv]
// Rank four corners by squared distance and register the ordered result word.
`default_nettype none

module rcod_sort (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire rcod_pkg::dist_vec_type   in_dist,
   input  wire rcod_pkg::corner_vec_type in_pts,
   output logic                       rsp_strobe,
   output rcod_pkg::rsp_word_type     rsp_word
);
   import rcod_pkg::*;

   logic [NUM_CORNERS-1:0][IDX_BITS-1:0] rank;
   corner_vec_type                       slot;
   logic                                 strobe_ff;
   rsp_word_type                         word_ff, word_in;

   // rank = number of corners that go ahead; equal distance keeps index order
   always_comb begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         rank[i] = '0;
         for (int j = 0; j < NUM_CORNERS; j++) begin
            if ((in_dist[j] < in_dist[i]) || ((in_dist[j] == in_dist[i]) && (j < i))) begin
               rank[i] = rank[i] + IDX_BITS'(1);
            end
         end
      end
   end

   // ranks form a permutation, so each slot picks exactly one corner
   always_comb begin
      for (int s = 0; s < NUM_CORNERS; s++) begin
         slot[s] = in_pts[0];
         for (int i = 0; i < NUM_CORNERS; i++) begin
            if (rank[i] == IDX_BITS'(s)) begin
               slot[s] = in_pts[i];
            end
         end
      end
   end

   always_comb begin
      word_in.o0_x = slot[0].x;
      word_in.o0_y = slot[0].y;
      word_in.o1_x = slot[1].x;
      word_in.o1_y = slot[1].y;
      word_in.o2_x = slot[2].x;
      word_in.o2_y = slot[2].y;
      word_in.o3_x = slot[3].x;
      word_in.o3_y = slot[3].y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = word_ff;

endmodule

`default_nettype wire

[rtl/rcod_checker.sv]
// Port-level checker for the rect corner order block, bound to the top level.
`default_nettype none
`include "rect_corner_order_by_distance_unit_macros.svh"

module rcod_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire rcod_pkg::req_word_type req_word,
   input wire logic                   rsp_strobe,
   input wire rcod_pkg::rsp_word_type rsp_word
);
   import rcod_pkg::*;

   function automatic logic is_corner(coord_type px, coord_type py, req_word_type w);
      return ((px == w.v0_x) && (py == w.v0_y)) || ((px == w.v1_x) && (py == w.v1_y)) ||
             ((px == w.v2_x) && (py == w.v2_y)) || ((px == w.v3_x) && (py == w.v3_y));
   endfunction

   `RCOD_ASSERT(a_never_busy, !busy)
   `RCOD_IMPLY(a_word_returns, start && !busy, ##RSP_LATENCY rsp_strobe)
   `RCOD_IMPLY(a_no_stray_rsp, rsp_strobe, $past(start && !busy, RSP_LATENCY))
   `RCOD_IMPLY(a_first_is_corner, rsp_strobe, is_corner(rsp_word.o0_x, rsp_word.o0_y, $past(req_word, RSP_LATENCY)))

endmodule

bind rect_corner_order_by_distance_unit rcod_checker u_rcod_checker (.*);

`default_nettype wire

[bench/rect_corner_order_by_distance_unit_test.sv]
// Self-checking testbench for the rect corner order by distance unit.
module rect_corner_order_by_distance_unit_test;
   import rcod_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   rsp_word_type expected_orders[$];
   rsp_word_type want_order;
   int           mismatches = 0;

   rect_corner_order_by_distance_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #3000000;
      $display("*** FAILED ***");
      $finish;
   end

   // larger y wins, then larger x
   function automatic bit ranks_higher(corner_type a, corner_type b);
      return (a.y > b.y) || (a.y == b.y && a.x > b.x);
   endfunction

   function automatic rsp_word_type order_by_distance(req_word_type w);
      corner_type        pts[NUM_CORNERS];
      corner_type        top1, top2, tmp, anchor;
      longint            dx, dy;
      longint            dsq[NUM_CORNERS];
      int                idx[NUM_CORNERS];
      int                i, j, k;
      rsp_word_type      r;
      pts[0] = '{x: w.v0_x, y: w.v0_y};
      pts[1] = '{x: w.v1_x, y: w.v1_y};
      pts[2] = '{x: w.v2_x, y: w.v2_y};
      pts[3] = '{x: w.v3_x, y: w.v3_y};
      top1 = pts[0];
      top2 = pts[1];
      if (ranks_higher(top2, top1)) begin
         tmp  = top1;
         top1 = top2;
         top2 = tmp;
      end
      for (i = 2; i < NUM_CORNERS; i++) begin
         if (ranks_higher(pts[i], top1)) begin
            top2 = top1;
            top1 = pts[i];
         end else if (ranks_higher(pts[i], top2)) begin
            top2 = pts[i];
         end
      end
      anchor = (top1.x >= top2.x) ? top1 : top2;
      for (i = 0; i < NUM_CORNERS; i++) begin
         dx     = longint'(anchor.x) - longint'(pts[i].x);
         dy     = longint'(anchor.y) - longint'(pts[i].y);
         dsq[i] = dx * dx + dy * dy;
         idx[i] = i;
      end
      // insertion sort, strict compare keeps equal distances in index order
      for (i = 1; i < NUM_CORNERS; i++) begin
         k = idx[i];
         j = i - 1;
         while (j >= 0 && dsq[idx[j]] > dsq[k]) begin
            idx[j + 1] = idx[j];
            j--;
         end
         idx[j + 1] = k;
      end
      r.o0_x = pts[idx[0]].x;
      r.o0_y = pts[idx[0]].y;
      r.o1_x = pts[idx[1]].x;
      r.o1_y = pts[idx[1]].y;
      r.o2_x = pts[idx[2]].x;
      r.o2_y = pts[idx[2]].y;
      r.o3_x = pts[idx[3]].x;
      r.o3_y = pts[idx[3]].y;
      return r;
   endfunction

   function automatic req_word_type quad(int x0, int y0, int x1, int y1,
                                         int x2, int y2, int x3, int y3);
      req_word_type w;
      w.v0_x = coord_type'(x0);
      w.v0_y = coord_type'(y0);
      w.v1_x = coord_type'(x1);
      w.v1_y = coord_type'(y1);
      w.v2_x = coord_type'(x2);
      w.v2_y = coord_type'(y2);
      w.v3_x = coord_type'(x3);
      w.v3_y = coord_type'(y3);
      return w;
   endfunction

   // values that provoke ties and range ends
   function automatic int edge_coord();
      case ($urandom_range(5))
         0: return -32768;
         1: return 32767;
         2: return -1;
         3: return 0;
         4: return 1;
         default: return int'($urandom_range(6)) - 3;
      endcase
   endfunction

   // exact rectangle: corners C, C+u, C+u+v, C+v with v = m * perp(u)
   function automatic req_word_type random_rect();
      int cx, cy, a, b, m, span, rot, s, k;
      bit rev;
      int ox[NUM_CORNERS], oy[NUM_CORNERS];
      int px[NUM_CORNERS], py[NUM_CORNERS];
      span = ($urandom_range(3) == 0) ? 3 : 2000;
      cx   = int'($urandom_range(32000)) - 16000;
      cy   = int'($urandom_range(32000)) - 16000;
      a    = int'($urandom_range(2 * span)) - span;
      b    = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(2 * span)) - span;
      m    = $urandom_range(1, 3);
      ox[0] = 0;          oy[0] = 0;
      ox[1] = a;          oy[1] = b;
      ox[2] = a - m * b;  oy[2] = b + m * a;
      ox[3] = -m * b;     oy[3] = m * a;
      rot = $urandom_range(3);
      rev = $urandom_range(1);
      for (k = 0; k < NUM_CORNERS; k++) begin
         s     = (rev ? (rot - k) : (rot + k)) & (NUM_CORNERS - 1);
         px[k] = cx + ox[s];
         py[k] = cy + oy[s];
      end
      return quad(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3]);
   endfunction

   function automatic req_word_type random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70)
         return random_rect();
      if (pick < 85)
         return quad(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                     edge_coord(), edge_coord(), edge_coord(), edge_coord());
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // called right after a rising edge; returns right after the accepting edge
   task automatic send_rect(input req_word_type w, input int idle_pct);
      bit took;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do begin
         @(negedge clock);
         took = !busy;
         @(posedge clock);
      end while (!took);
      expected_orders = {expected_orders, order_by_distance(w)};
   endtask

   task automatic check_coord(input string name, input coord_type want,
                              input coord_type got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // results hold for one full cycle, so the falling edge sees them settled
   always @(negedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_orders.size() == 0) begin
            $error("result word with none expected: %h", rsp_word);
            mismatches++;
         end else begin
            want_order = expected_orders.pop_front();
            check_coord("o0_x", want_order.o0_x, rsp_word.o0_x);
            check_coord("o0_y", want_order.o0_y, rsp_word.o0_y);
            check_coord("o1_x", want_order.o1_x, rsp_word.o1_x);
            check_coord("o1_y", want_order.o1_y, rsp_word.o1_y);
            check_coord("o2_x", want_order.o2_x, rsp_word.o2_x);
            check_coord("o2_y", want_order.o2_y, rsp_word.o2_y);
            check_coord("o3_x", want_order.o3_x, rsp_word.o3_x);
            check_coord("o3_y", want_order.o3_y, rsp_word.o3_y);
         end
      end
   end

   task automatic test_corner_cases();
      // all corners coincide, at zero and at both range ends
      send_rect(quad(0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_rect(quad(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 0);
      send_rect(quad(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768), 0);
      // full-range square, largest distances
      send_rect(quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767), 0);
      send_rect(quad(32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768), 0);
      // axis aligned: top edge shares y
      send_rect(quad(0, 0, 160, 0, 160, 80, 0, 80), 0);
      // square: two corners at equal distance keep index order
      send_rect(quad(0, 0, 16, 0, 16, 16, 0, 16), 0);
      send_rect(quad(0, 16, 16, 16, 16, 0, 0, 0), 0);
      // diamond: second ranked corner has the larger x
      send_rect(quad(0, 160, 160, 0, 0, -160, -160, 0), 0);
      // top two share x, higher ranked one is taken
      send_rect(quad(80, 0, 80, 160, 80, 320, 0, 0), 0);
      // coincident pairs and identical top corners
      send_rect(quad(48, 48, 48, 48, -16, -16, -16, -16), 0);
      send_rect(quad(5, 5, 5, 5, 5, 5, 0, 0), 0);
      // all on one row
      send_rect(quad(-5, 7, 3, 7, 9, 7, -20, 7), 0);
      // later corners displace the running top two
      send_rect(quad(0, 0, 10, 10, 20, 40, 30, 30), 0);
      // sign bit patterns
      send_rect(quad(-32768, 32767, -1, 1, 1, -1, 32767, -32768), 0);
      // rotated rectangle, both winding orders
      send_rect(quad(0, 0, 48, 32, 16, 80, -32, 48), 0);
      send_rect(quad(-32, 48, 16, 80, 48, 32, 0, 0), 0);
   endtask

   task automatic run_random(input int count, input int idle_pct);
      repeat (count) send_rect(random_item(), idle_pct);
   endtask

   task automatic test_back_to_back();
      run_random(345, 0);
   endtask

   task automatic test_sparse_sender();
      run_random(345, 70);
   endtask

   task automatic test_mixed_gaps();
      run_random(345, 37);
   endtask

   task automatic test_back_to_back_tail();
      run_random(345, 0);
   endtask

   initial begin
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_corner_cases();
      test_back_to_back();
      test_sparse_sender();
      test_mixed_gaps();
      test_back_to_back_tail();
      start <= 1'b0;
      for (n = 0; n < 1000 && expected_orders.size() != 0; n++)
         @(posedge clock);
      repeat (RSP_LATENCY + 4) @(posedge clock);
      if (expected_orders.size() != 0) begin
         $error("%0d result words never arrived", expected_orders.size());
         mismatches += expected_orders.size();
      end
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[rect_corner_order_by_distance_unit.f]
+incdir+rtl
rtl/rcod_pkg.sv
rtl/rcod_sort.sv
rtl/rect_corner_order_by_distance_unit.sv
rtl/rcod_checker.sv
bench/rect_corner_order_by_distance_unit_test.sv
